>>> hdl/bmd_pkg.sv
// Shared types for the block median decimator.
// No dependencies; imported by bmd_store and block_median_decimator_core.
`default_nettype none

package bmd_pkg;

   // Signed Q16.16 coordinate sample.
   typedef logic signed [31:0] sample_type;

endpackage

`default_nettype wire

>>> hdl/bmd_store.sv
// Sample store for the block median decimator: one write port, one read port.
// The read data is registered, so it appears in the cycle after the address. Uses bmd_pkg.
`default_nettype none

module bmd_store
   import bmd_pkg::*;
#(
   parameter int DEPTH = 19,
   parameter int AW    = 5
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire sample_type    wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output sample_type         rd_data
);

   sample_type mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> hdl/block_median_decimator_core.sv
// Block median decimator: every request returns the held block median and a fresh flag.
// Stored samples are kept sorted in bmd_store by insertion, one compare-and-shift per cycle.
// Path from an accepted request to rsp_valid: the first sample of a block is written to
// the bottom, then ST_DONE; a later stored sample walks ST_CMP, one store entry per cycle
// (and ST_LOW when it is the smallest), then ST_DONE; the closing request of a block reads
// the median entry in ST_MED, then ST_DONE. req_stall holds off the next request until
// ST_DONE loads the response register, which waits while rsp_stall holds the last response.
// Reset (synchronous): frame counter to 1, held median to 0, no result pending.
`default_nettype none

module block_median_decimator_core
   import bmd_pkg::*;
#(
   parameter int WINDOW = 20
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire sample_type  req_sample,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output sample_type       rsp_held_median,
   output logic             rsp_fresh
);

   localparam int DEPTH     = WINDOW - 1;
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW        = $clog2(WINDOW + 1);
   localparam int MED_INDEX = (WINDOW - 2) / 2;

   localparam logic [AW-1:0] MED_ADDR = AW'(MED_INDEX);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CMP  = 3'd1;
   localparam logic [2:0] ST_LOW  = 3'd2;
   localparam logic [2:0] ST_MED  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [FW-1:0] frame_count_ff, frame_count_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   sample_type    sample_ff, sample_in;
   sample_type    held_ff, held_in;
   logic          fresh_ff, fresh_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sample_type    rsp_held_ff, rsp_held_in;
   logic          rsp_fresh_ff, rsp_fresh_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   sample_type    wr_data;
   logic [AW-1:0] rd_addr;
   sample_type    rd_data;

   bmd_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: insert each sample into the sorted store, or pick the median entry.
   always_comb begin
      state_in       = state_ff;
      frame_count_in = frame_count_ff;
      ptr_in         = ptr_ff;
      sample_in      = sample_ff;
      held_in        = held_ff;
      fresh_in       = fresh_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_held_in    = rsp_held_ff;
      rsp_fresh_in   = rsp_fresh_ff;
      wr_en          = 1'b0;
      wr_addr        = ptr_ff + AW'(1);
      wr_data        = sample_ff;
      rd_addr        = ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               if (frame_count_ff == FW'(WINDOW)) begin
                  // Closing frame: the sample is dropped and the median entry is read.
                  rd_addr        = MED_ADDR;
                  frame_count_in = FW'(1);
                  state_in       = ST_MED;
               end else begin
                  fresh_in       = 1'b0;
                  frame_count_in = frame_count_ff + FW'(1);
                  if (frame_count_ff == FW'(1)) begin
                     // First sample of a block goes straight to the bottom.
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     wr_data  = req_sample;
                     state_in = ST_DONE;
                  end else begin
                     // Start at the top of the sorted entries and work downward.
                     ptr_in   = AW'(frame_count_ff - FW'(2));
                     rd_addr  = AW'(frame_count_ff - FW'(2));
                     state_in = ST_CMP;
                  end
               end
            end
         end

         ST_CMP: begin
            // Shift larger entries up by one until the sample's place is found.
            wr_en = 1'b1;
            if (rd_data > sample_ff) begin
               wr_data = rd_data;
               if (ptr_ff == '0) begin
                  state_in = ST_LOW;
               end else begin
                  ptr_in  = ptr_ff - AW'(1);
                  rd_addr = ptr_ff - AW'(1);
               end
            end else begin
               wr_data  = sample_ff;
               state_in = ST_DONE;
            end
         end

         ST_LOW: begin
            // The sample is the smallest so far.
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = sample_ff;
            state_in = ST_DONE;
         end

         ST_MED: begin
            held_in  = rd_data;
            fresh_in = 1'b1;
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // Load the response register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_held_in  = held_ff;
               rsp_fresh_in = fresh_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and held state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_count_ff <= FW'(1);
         held_ff        <= '0;
         fresh_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_count_ff <= frame_count_in;
         held_ff        <= held_in;
         fresh_ff       <= fresh_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      sample_ff    <= sample_in;
      rsp_held_ff  <= rsp_held_in;
      rsp_fresh_ff <= rsp_fresh_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_held_median = rsp_held_ff;
   assign rsp_fresh       = rsp_fresh_ff;

endmodule

`default_nettype wire
